// File: rtl/rmq_pkg.sv
// Package for the multilevel ready queue: sizes, operation codes and the
// structs passed between the task cells, the head selector and the top level.
// No dependencies.
package rmq_pkg;

  localparam int NUM_LEVELS = 64;
  localparam int MAX_TASKS  = 64;
  localparam int TASK_W     = $clog2(MAX_TASKS);
  localparam int LVL_W      = $clog2(NUM_LEVELS);
  localparam int CNT_W      = $clog2(MAX_TASKS + 1);

  typedef enum logic [1:0] {
    KIND_PUSH    = 2'd0,
    KIND_POP     = 2'd1,
    KIND_PEEK    = 2'd2,
    KIND_REQUEUE = 2'd3
  } kind_t;

  // Update applied to the task cells at the end of one operation.
  typedef struct packed {
    logic              push_new;  // enqueue a task that was not queued
    logic              move;      // move a queued task to the tail of a new level
    logic [TASK_W-1:0] task_id;   // task for push_new or move
    logic [LVL_W-1:0]  level;     // destination level for push_new or move
    logic              drop;      // dequeue the task below
    logic [TASK_W-1:0] drop_task;
  } cell_cmd_t;

  // Head of the highest non-empty level.
  typedef struct packed {
    logic              found;
    logic [TASK_W-1:0] task_id;
    logic [LVL_W-1:0]  level;
  } pick_t;

endpackage

// File: rtl/rmq_cells.sv
// Task cells of the ready queue: queued bit, level and age row per task,
// plus the count of queued tasks.
// Depends on rmq_pkg.
module rmq_cells (
  input  logic                                              clk,
  input  logic                                              rst,
  input  rmq_pkg::cell_cmd_t                                cmd,
  output logic [rmq_pkg::MAX_TASKS-1:0]                     queued,
  output logic [rmq_pkg::MAX_TASKS-1:0][rmq_pkg::LVL_W-1:0] task_lvl,
  output logic [rmq_pkg::MAX_TASKS-1:0][rmq_pkg::MAX_TASKS-1:0] ahead,
  output logic [rmq_pkg::CNT_W-1:0]                         count
);

  logic append;

  assign append = cmd.push_new | cmd.move;

  // Control state: which tasks are queued, and how many.
  always_ff @(posedge clk) begin
    if (rst) begin
      queued <= '0;
      count  <= '0;
    end else begin
      for (int i = 0; i < rmq_pkg::MAX_TASKS; i++) begin
        if (cmd.push_new && cmd.task_id == rmq_pkg::TASK_W'(i)) begin
          queued[i] <= 1'b1;
        end else if (cmd.drop && cmd.drop_task == rmq_pkg::TASK_W'(i)) begin
          queued[i] <= 1'b0;
        end
      end
      if (cmd.push_new) begin
        count <= count + rmq_pkg::CNT_W'(1);
      end else if (cmd.drop) begin
        count <= count - rmq_pkg::CNT_W'(1);
      end
    end
  end

  // ahead[i][j] is set when task j entered its level before task i. An
  // appended task goes behind every other task; the relation between two
  // tasks is rewritten whenever the later of them is appended, so stale bits
  // never matter.
  always_ff @(posedge clk) begin
    for (int i = 0; i < rmq_pkg::MAX_TASKS; i++) begin
      if (append && cmd.task_id == rmq_pkg::TASK_W'(i)) begin
        task_lvl[i] <= cmd.level;
        ahead[i]    <= ~(rmq_pkg::MAX_TASKS'(1) << i);
      end else if (append) begin
        ahead[i][cmd.task_id] <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/rmq_select.sv
// Head selector of the ready queue: finds the highest non-empty level and
// the oldest task on it.
// Depends on rmq_pkg.
module rmq_select (
  input  logic [rmq_pkg::MAX_TASKS-1:0]                         queued,
  input  logic [rmq_pkg::MAX_TASKS-1:0][rmq_pkg::LVL_W-1:0]     task_lvl,
  input  logic [rmq_pkg::MAX_TASKS-1:0][rmq_pkg::MAX_TASKS-1:0] ahead,
  output rmq_pkg::pick_t                                        pick
);

  logic [rmq_pkg::NUM_LEVELS-1:0] nonempty;
  logic [rmq_pkg::LVL_W-1:0]      top_lvl;
  logic                           any;
  logic [rmq_pkg::MAX_TASKS-1:0]  cand;
  logic [rmq_pkg::MAX_TASKS-1:0]  head;
  logic [rmq_pkg::TASK_W-1:0]     head_idx;

  always_comb begin
    nonempty = '0;
    for (int l = 0; l < rmq_pkg::NUM_LEVELS; l++) begin
      for (int i = 0; i < rmq_pkg::MAX_TASKS; i++) begin
        if (queued[i] && task_lvl[i] == rmq_pkg::LVL_W'(l)) begin
          nonempty[l] = 1'b1;
        end
      end
    end
  end

  // Priority encoder: the last set bit scanned upwards is the highest level.
  always_comb begin
    any     = 1'b0;
    top_lvl = '0;
    for (int l = 0; l < rmq_pkg::NUM_LEVELS; l++) begin
      if (nonempty[l]) begin
        any     = 1'b1;
        top_lvl = rmq_pkg::LVL_W'(l);
      end
    end
  end

  // The head is the one candidate with no other candidate ahead of it.
  always_comb begin
    head_idx = '0;
    for (int i = 0; i < rmq_pkg::MAX_TASKS; i++) begin
      cand[i] = queued[i] && task_lvl[i] == top_lvl;
    end
    for (int i = 0; i < rmq_pkg::MAX_TASKS; i++) begin
      head[i] = cand[i] && !(|(cand & ahead[i]));
    end
    for (int i = 0; i < rmq_pkg::MAX_TASKS; i++) begin
      if (head[i]) begin
        head_idx = head_idx | rmq_pkg::TASK_W'(i);
      end
    end
  end

  assign pick.found   = any;
  assign pick.task_id = head_idx;
  assign pick.level   = top_lvl;

endmodule

// File: rtl/multilevel_ready_queue_unit.sv
// Top level of the multilevel ready queue: input register, operation decode,
// result register and the stream handshakes.
// Depends on rmq_pkg, rmq_cells and rmq_select.
//
//   channel  dir  tdata (low bit up)                          tuser (low bit up)
//   s_*      in   task_id[5:0], level[11:6], zero [15:12]     kind[1:0]
//   m_*      out  chosen_task[5:0], chosen_level[11:6],       none_ready[0],
//                 task_count[18:12], zero [23:19]             op_error[1]
//
// An input transfer lands in the input register; once the result register
// is free or is being emptied, the operation is decoded, the head of the
// highest non-empty level is found by a priority encoder over the levels
// and an age compare among the tasks of that level, the task cells are
// updated and the result is registered. One operation per cycle is
// sustained while m_tready stays high; the head search is the longest path.
// Reset clears the queued bits, the task count and both valid flags. While
// m_tready is low the result holds and the input register, if empty, still
// takes one more transfer before s_tready falls.
module multilevel_ready_queue_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // task_id[5:0], level[11:6]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // chosen_task[5:0], chosen_level[11:6], task_count[18:12]
  output logic [1:0]  m_tuser    // none_ready[0], op_error[1]
);

  // Input register.
  logic                       in_valid;
  rmq_pkg::kind_t             in_kind;
  logic [rmq_pkg::TASK_W-1:0] in_task;
  logic [rmq_pkg::LVL_W-1:0]  in_level;

  // Result register.
  logic [rmq_pkg::TASK_W-1:0] out_task;
  logic [rmq_pkg::LVL_W-1:0]  out_level;
  logic [rmq_pkg::CNT_W-1:0]  out_count;
  logic                       out_none;
  logic                       out_err;

  // Operation results.
  logic [rmq_pkg::TASK_W-1:0] res_task;
  logic [rmq_pkg::LVL_W-1:0]  res_level;
  logic [rmq_pkg::CNT_W-1:0]  res_count;
  logic                       res_none;
  logic                       res_err;

  logic                       advance;
  rmq_pkg::cell_cmd_t         cmd;
  rmq_pkg::pick_t             pick;

  logic [rmq_pkg::MAX_TASKS-1:0]                         queued;
  logic [rmq_pkg::MAX_TASKS-1:0][rmq_pkg::LVL_W-1:0]     task_lvl;
  logic [rmq_pkg::MAX_TASKS-1:0][rmq_pkg::MAX_TASKS-1:0] ahead;
  logic [rmq_pkg::CNT_W-1:0]                             count;

  // The held operation completes when the result register is free or is
  // being emptied in this cycle.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind  <= rmq_pkg::kind_t'(s_tuser);
      in_task  <= s_tdata[5:0];
      in_level <= s_tdata[11:6];
    end
  end

  rmq_cells u_cells (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .queued   (queued),
    .task_lvl (task_lvl),
    .ahead    (ahead),
    .count    (count)
  );

  rmq_select u_select (
    .queued   (queued),
    .task_lvl (task_lvl),
    .ahead    (ahead),
    .pick     (pick)
  );

  // Decode the held operation into a cell update and its result. Nothing is
  // written to the cells unless the operation completes in this cycle.
  always_comb begin
    cmd           = '0;
    cmd.task_id   = in_task;
    cmd.level     = in_level;
    cmd.drop_task = pick.task_id;
    res_task      = '0;
    res_level     = '0;
    res_err       = 1'b0;
    unique case (in_kind)
      rmq_pkg::KIND_PUSH: begin
        // A push of a task that is already queued changes nothing.
        if (queued[in_task]) begin
          res_err = 1'b1;
        end else begin
          cmd.push_new = advance;
        end
      end
      rmq_pkg::KIND_REQUEUE: begin
        // Requeue to the same level, or of a task not queued, is a no-op.
        cmd.move = advance && queued[in_task] && task_lvl[in_task] != in_level;
      end
      rmq_pkg::KIND_POP, rmq_pkg::KIND_PEEK: begin
        if (pick.found) begin
          res_task  = pick.task_id;
          res_level = pick.level;
          cmd.drop  = advance && in_kind == rmq_pkg::KIND_POP;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_count = count;
    if (in_kind == rmq_pkg::KIND_PUSH && !queued[in_task]) begin
      res_count = count + rmq_pkg::CNT_W'(1);
    end else if (in_kind == rmq_pkg::KIND_POP && pick.found) begin
      res_count = count - rmq_pkg::CNT_W'(1);
    end
    if (in_kind == rmq_pkg::KIND_POP || in_kind == rmq_pkg::KIND_PEEK) begin
      res_none = !pick.found;
    end else begin
      res_none = res_count == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_task  <= res_task;
      out_level <= res_level;
      out_count <= res_count;
      out_none  <= res_none;
      out_err   <= res_err;
    end
  end

  assign m_tdata = {5'd0, out_count, out_level, out_task};
  assign m_tuser = {out_err, out_none};

endmodule

// File: sim/multilevel_ready_queue_unit_tb.sv
// Self-checking testbench for the multilevel ready queue: a directed sequence,
// a fill-and-drain of every task, a long result stall and random traffic.
// Depends on rmq_pkg and multilevel_ready_queue_unit.
module multilevel_ready_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rmq_pkg::*;

  localparam int RESET_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_CAP    = 50;

  // One result as the block reports it.
  typedef struct packed {
    logic [TASK_W-1:0] chosen_task;
    logic [LVL_W-1:0]  chosen_level;
    logic              none_ready;
    logic              op_error;
    logic [CNT_W-1:0]  task_count;
  } sched_result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = KIND_PUSH;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  // Our own view of the queue: one FIFO of task ids per level.
  logic [TASK_W-1:0] level_fifo [NUM_LEVELS][$];
  logic [LVL_W-1:0]  level_of_task [MAX_TASKS];
  bit                task_queued [MAX_TASKS];
  int unsigned       ready_total;
  sched_result_t     expected_results [$];

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  int unsigned hold_asked     = 0;
  int unsigned hold_granted   = 0;
  int unsigned hold_left      = 0;

  multilevel_ready_queue_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Applies one operation to the predicted queue and returns its result.
  function automatic sched_result_t ready_queue_apply(kind_t op, logic [TASK_W-1:0] tid,
                                                      logic [LVL_W-1:0] lvl);
    sched_result_t    r;
    int               idx;
    int               top;
    logic [LVL_W-1:0] old;
    r   = '0;
    top = -1;
    case (op)
      KIND_PUSH: begin
        if (task_queued[tid]) begin
          r.op_error = 1'b1;
        end else begin
          level_fifo[lvl].push_back(tid);
          level_of_task[tid] = lvl;
          task_queued[tid]   = 1'b1;
          ready_total++;
        end
        r.none_ready = (ready_total == 0);
      end
      KIND_REQUEUE: begin
        if (task_queued[tid] && level_of_task[tid] != lvl) begin
          old = level_of_task[tid];
          for (idx = 0; idx < level_fifo[old].size(); idx++) begin
            if (level_fifo[old][idx] == tid) break;
          end
          level_fifo[old].delete(idx);
          level_fifo[lvl].push_back(tid);
          level_of_task[tid] = lvl;
        end
        r.none_ready = (ready_total == 0);
      end
      default: begin
        // Pop and peek both look at the head of the highest non-empty level.
        for (idx = NUM_LEVELS - 1; idx >= 0 && top < 0; idx--) begin
          if (level_fifo[idx].size() != 0) top = idx;
        end
        if (top < 0) begin
          r.none_ready = 1'b1;
        end else begin
          r.chosen_task  = level_fifo[top][0];
          r.chosen_level = LVL_W'(top);
          if (op == KIND_POP) begin
            void'(level_fifo[top].pop_front());
            task_queued[r.chosen_task] = 1'b0;
            ready_total--;
          end
        end
      end
    endcase
    r.task_count = CNT_W'(ready_total);
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_count++;
    // Keep the log short when the block is badly broken.
    if (mismatch_count <= PRINT_CAP)
      $display("mismatch at cycle %0d: %s expected %0d, got %0d", cycle_count, what, want, got);
  endtask

  // Offers one operation, with random gaps before it, and predicts its result
  // once the transfer has happened. The valid stays high for the next item.
  task automatic send_op(kind_t op, logic [TASK_W-1:0] tid, logic [LVL_W-1:0] lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, lvl, tid};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(ready_queue_apply(op, tid, lvl));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Returns a random task that is queued, or one that is not.
  function automatic logic [TASK_W-1:0] pick_task(bit want_queued);
    logic [TASK_W-1:0] t;
    t = TASK_W'($urandom_range(MAX_TASKS - 1));
    while (task_queued[t] != want_queued) t = TASK_W'($urandom_range(MAX_TASKS - 1));
    return t;
  endfunction

  // Mostly well-formed operations: pushes of idle tasks, requeues of queued
  // ones, pops and peeks, on a handful of busy levels so that the FIFOs get deep.
  task automatic send_random_op();
    int unsigned       roll;
    kind_t             op;
    logic [TASK_W-1:0] tid;
    logic [LVL_W-1:0]  lvl;
    roll = $urandom_range(99);
    tid  = TASK_W'($urandom_range(MAX_TASKS - 1));
    if ($urandom_range(3) == 0) lvl = LVL_W'($urandom_range(NUM_LEVELS - 1));
    else lvl = LVL_W'($urandom_range(3) * 21);
    if (roll < 35) begin
      op = KIND_PUSH;
      if (roll < 31 && ready_total < MAX_TASKS) tid = pick_task(1'b0);
    end else if (roll < 55) begin
      op = KIND_REQUEUE;
      if (roll < 51 && ready_total != 0) tid = pick_task(1'b1);
    end else if (roll < 85) begin
      op = KIND_POP;
    end else begin
      op = KIND_PEEK;
    end
    send_op(op, tid, lvl);
  endtask

  // Empty queue, duplicate push, requeue to the same level and of an idle
  // task, and requeue from the head, middle and tail of a level.
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct    <= 0;
    send_op(KIND_PEEK, 6'd0, 6'd0);
    send_op(KIND_POP, 6'd63, 6'd63);
    send_op(KIND_REQUEUE, 6'd5, 6'd9);
    send_op(KIND_PUSH, 6'd0, 6'd0);
    send_op(KIND_PUSH, 6'd63, 6'd63);
    send_op(KIND_PUSH, 6'd63, 6'd10);
    send_op(KIND_PUSH, 6'd42, 6'd63);
    send_op(KIND_PEEK, 6'd21, 6'd21);
    send_op(KIND_REQUEUE, 6'd63, 6'd63);
    send_op(KIND_PUSH, 6'd1, 6'd10);
    send_op(KIND_PUSH, 6'd2, 6'd10);
    send_op(KIND_PUSH, 6'd3, 6'd10);
    send_op(KIND_REQUEUE, 6'd2, 6'd11);
    send_op(KIND_REQUEUE, 6'd3, 6'd11);
    send_op(KIND_REQUEUE, 6'd1, 6'd11);
    send_op(KIND_REQUEUE, 6'd0, 6'd63);
    send_op(KIND_REQUEUE, 6'd63, 6'd0);
    repeat (7) send_op(KIND_POP, 6'd0, 6'd0);
    send_op(KIND_PEEK, 6'd0, 6'd0);
    wait_drained();
  endtask

  // Every task queued at once, so the count reaches its top, then drained.
  task automatic test_fill_all();
    logic [TASK_W-1:0] order [MAX_TASKS];
    logic [TASK_W-1:0] swap;
    int unsigned       j;
    send_idle_pct = 0;
    stall_pct    <= 61;
    for (int i = 0; i < MAX_TASKS; i++) order[i] = TASK_W'(i);
    for (int i = MAX_TASKS - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      swap     = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    for (int i = 0; i < MAX_TASKS; i++) begin
      send_op(KIND_PUSH, order[i], LVL_W'($urandom_range(NUM_LEVELS - 1)));
    end
    send_op(KIND_PEEK, 6'd0, 6'd0);
    send_op(KIND_PUSH, order[0], 6'd0);
    repeat (MAX_TASKS + 1) send_op(KIND_POP, 6'd0, 6'd0);
    wait_drained();
  endtask

  // The result side holds off for a long stretch while operations keep
  // coming, so the block fills and refuses further transfers.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct    <= 0;
    hold_asked   <= hold_asked + 1;
    repeat (40) send_random_op();
    wait_drained();
  endtask

  task automatic test_random(int unsigned idle_pct, int unsigned stall, int unsigned count);
    send_idle_pct = idle_pct;
    stall_pct    <= stall;
    repeat (count) send_random_op();
    wait_drained();
  endtask

  // Result-side ready: random stalls, or a long hold when one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_granted) begin
      hold_granted <= hold_asked;
      hold_left    <= HOLD_CYCLES;
      m_tready     <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Each result transfer is compared with the oldest prediction.
  always @(posedge clk) begin : result_check
    sched_result_t got;
    sched_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.chosen_task  = m_tdata[5:0];
      got.chosen_level = m_tdata[11:6];
      got.task_count   = m_tdata[18:12];
      got.none_ready   = m_tuser[0];
      got.op_error     = m_tuser[1];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, chosen_task", 0, got.chosen_task);
      end else begin
        want = expected_results.pop_front();
        if (got.chosen_task != want.chosen_task)
          report_mismatch("chosen_task", want.chosen_task, got.chosen_task);
        if (got.chosen_level != want.chosen_level)
          report_mismatch("chosen_level", want.chosen_level, got.chosen_level);
        if (got.none_ready != want.none_ready)
          report_mismatch("none_ready", want.none_ready, got.none_ready);
        if (got.op_error != want.op_error)
          report_mismatch("op_error", want.op_error, got.op_error);
        if (got.task_count != want.task_count)
          report_mismatch("task_count", want.task_count, got.task_count);
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_all();
    test_backpressure();
    test_random(0, 0, 190);
    test_random(61, 0, 190);
    test_random(0, 61, 190);
    test_random(6, 6, 190);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
